// ===== sv/mngt_pkg.sv =====
// ---------------------------------------------------------------------------
// mngt_pkg: shared types and constants for the MIDI note gate/trigger unit
// Holds opcodes, reset values, the sequencer state type and the command and
// status groups passed between controller and datapath.
// ---------------------------------------------------------------------------
package mngt_pkg;

  // Default depth of the held-note stack
  localparam int STACK_DEPTH_DEF = 16;

  // Field widths fixed by the item formats
  localparam int NOTE_W   = 7;
  localparam int TICKS_W  = 16;
  localparam int IN_DW    = 24;
  localparam int OUT_DW   = 24;

  // MIDI status opcodes (high nibble of the status byte)
  localparam logic [3:0] OPC_NOTE_OFF = 4'h8;
  localparam logic [3:0] OPC_NOTE_ON  = 4'h9;

  // Item kind carried in tuser
  localparam logic OP_MIDI = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Only complete three-byte note messages are acted on
  localparam logic [1:0] MSG_LEN_FULL = 2'd3;

  // Reset values
  localparam logic [NOTE_W-1:0]  NOTE_RESET        = 7'd69;
  localparam logic [TICKS_W-1:0] PULSE_TICKS_RESET = 16'd100;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND_RD,
    S_FIND_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_POST,
    S_TOP,
    S_DONE
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;    // latch the incoming item
    logic rd_find;   // read stack at scan index
    logic idx_inc;   // advance scan/shift index
    logic idx_clr;   // restart index at the bottom entry
    logic rd_shift;  // read entry above the index
    logic wr_shift;  // write read data one entry down
    logic count_dec; // drop one entry from the fill count
    logic push;      // write note on top, grow count
    logic gate_clr;  // drop the gate
    logic rd_top;    // read the top entry
    logic top_load;  // replay top note and retrigger
    logic out_load;  // load the result register
  } mngt_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic note_cmd;  // incoming item is a well-formed note command
    logic is_on;     // latched command is note-on
    logic idx_end;   // scan index reached the fill count
    logic match;     // read data equals latched note
    logic shift_end; // no entry left above the index
    logic cnt_zero;  // stack empty
    logic cnt_full;  // stack full
    logic out_free;  // result register can take a new item
  } mngt_status_t;

endpackage

// ===== sv/midi_note_gate_trigger_unit.sv =====
// ---------------------------------------------------------------------------
// midi_note_gate_trigger_unit: monophonic MIDI gate/trigger, last-note priority
// Takes MIDI note messages and timer ticks, keeps a held-note stack and
// returns one result of gate, trigger, note, velocity and format error per item.
//
//  channel  ports      direction  contents
//  input    in_*       slave      tuser: op; tdata: status, note, velocity, len
//  result   out_*      master     tdata: gate, trig, note, velocity, error
//  config   cfg_*      write      pulse_ticks, 16 bit
//
// Ticks, ignored and malformed items go straight to the result step.
// A note command scans the stack entry by entry (read, compare), then
// moves the entries above a match down (read, write), through the single
// read port of the stack RAM. Reset is synchronous and needs no clearing
// pass. The result register frees the input as soon as a result is
// loaded; a stalled result holds back only the next result.
// ---------------------------------------------------------------------------
module midi_note_gate_trigger_unit #(
  parameter int STACK_DEPTH = mngt_pkg::STACK_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // [7:0] status, [14:8] data_one, [21:15] data_two, [23:22] msg_len
  input  logic [mngt_pkg::IN_DW-1:0]   in_tdata,
  // [0] op
  input  logic                         in_tuser,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // [0] gate, [1] trig, [8:2] note_out, [15:9] velocity_out,
  // [16] format_error, [23:17] zero
  output logic [mngt_pkg::OUT_DW-1:0]  out_tdata,
  input  logic                         cfg_we,
  input  logic [mngt_pkg::TICKS_W-1:0] cfg_wdata
);
  import mngt_pkg::*;

  mngt_cmd_t    cmd;
  mngt_status_t st;

  mngt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  mngt_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .st         (st)
  );

endmodule

// ===== sv/mngt_ram.sv =====
// ---------------------------------------------------------------------------
// mngt_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module mngt_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/mngt_ctrl.sv =====
// ---------------------------------------------------------------------------
// mngt_ctrl: sequencer for the held-note stack
// Walks find, compact, push and replay steps and hands commands to the
// datapath; one item is in work at a time.
// ---------------------------------------------------------------------------
module mngt_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  mngt_pkg::mngt_status_t st,
  output mngt_pkg::mngt_cmd_t   cmd
);
  import mngt_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = st.note_cmd ? S_FIND_RD : S_DONE;
        end
      end
      S_FIND_RD: begin
        if (!st.idx_end) begin
          state_nxt = S_FIND_CMP;
        end else if (st.is_on && st.cnt_full) begin
          state_nxt = S_SHIFT_RD;
        end else begin
          state_nxt = S_POST;
        end
      end
      S_FIND_CMP: begin
        state_nxt = st.match ? S_SHIFT_RD : S_FIND_RD;
      end
      S_SHIFT_RD: begin
        state_nxt = st.shift_end ? S_POST : S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        state_nxt = S_SHIFT_RD;
      end
      S_POST: begin
        if (st.is_on || st.cnt_zero) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_TOP;
        end
      end
      S_TOP: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (st.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      S_FIND_RD: begin
        if (!st.idx_end) begin
          cmd.rd_find = 1'b1;
        end else if (st.is_on && st.cnt_full) begin
          cmd.idx_clr = 1'b1;
        end
      end
      S_FIND_CMP: begin
        cmd.idx_inc = !st.match;
      end
      S_SHIFT_RD: begin
        cmd.count_dec = st.shift_end;
        cmd.rd_shift  = !st.shift_end;
      end
      S_SHIFT_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.idx_inc  = 1'b1;
      end
      S_POST: begin
        if (st.is_on) begin
          cmd.push = 1'b1;
        end else if (st.cnt_zero) begin
          cmd.gate_clr = 1'b1;
        end else begin
          cmd.rd_top = 1'b1;
        end
      end
      S_TOP: begin
        cmd.top_load = 1'b1;
      end
      S_DONE: begin
        cmd.out_load = st.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ===== sv/mngt_dp.sv =====
// ---------------------------------------------------------------------------
// mngt_dp: datapath of the MIDI note gate/trigger unit
// Holds the note stack RAM, fill count, output levels, pulse timer and the
// result register; acts on commands from the sequencer.
// ---------------------------------------------------------------------------
module mngt_dp #(
  parameter int STACK_DEPTH = mngt_pkg::STACK_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [mngt_pkg::IN_DW-1:0]        in_tdata,
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [mngt_pkg::OUT_DW-1:0]       out_tdata,
  input  logic                              cfg_we,
  input  logic [mngt_pkg::TICKS_W-1:0]      cfg_wdata,
  input  mngt_pkg::mngt_cmd_t               cmd,
  output mngt_pkg::mngt_status_t            st
);
  import mngt_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(STACK_DEPTH);

  // Input fields
  logic [7:0]        in_status;
  logic [NOTE_W-1:0] in_d1;
  logic [NOTE_W-1:0] in_d2;
  logic [1:0]        in_len;
  logic              in_is_note;
  logic              in_is_on;
  logic              in_len_ok;

  assign in_status  = in_tdata[7:0];
  assign in_d1      = in_tdata[14:8];
  assign in_d2      = in_tdata[21:15];
  assign in_len     = in_tdata[23:22];
  assign in_is_on   = (in_status[7:4] == OPC_NOTE_ON);
  assign in_is_note = in_is_on || (in_status[7:4] == OPC_NOTE_OFF);
  assign in_len_ok  = (in_len == MSG_LEN_FULL);

  // Registers
  logic [TICKS_W-1:0] pulse_ticks_r, pulse_ticks_nxt;
  logic [TICKS_W-1:0] elapsed_r, elapsed_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic               gate_r, gate_nxt;
  logic               trig_r, trig_nxt;
  logic [NOTE_W-1:0]  cur_note_r, cur_note_nxt;
  logic [NOTE_W-1:0]  cur_vel_r, cur_vel_nxt;
  logic [NOTE_W-1:0]  note_r, note_nxt;
  logic               is_on_r, is_on_nxt;
  logic               err_r, err_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [OUT_DW-1:0]  out_data_r, out_data_nxt;

  // RAM signals
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [NOTE_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [NOTE_W-1:0] ram_rdata;

  logic [TICKS_W-1:0] elapsed_inc;
  logic [CW:0]        idx_plus1;
  logic [CW-1:0]      count_m1;

  assign elapsed_inc = (elapsed_r == '1) ? elapsed_r : elapsed_r + TICKS_W'(1);
  assign idx_plus1   = {1'b0, idx_r} + (CW+1)'(1);
  assign count_m1    = count_r - CW'(1);

  // Status toward the sequencer
  always_comb begin
    st           = '0;
    st.note_cmd  = (in_tuser == OP_MIDI) && in_is_note && in_len_ok;
    st.is_on     = is_on_r;
    st.idx_end   = (idx_r == count_r);
    st.match     = (ram_rdata == note_r);
    st.shift_end = (idx_plus1 >= {1'b0, count_r});
    st.cnt_zero  = (count_r == '0);
    st.cnt_full  = (count_r == CNT_FULL);
    st.out_free  = !out_valid_r || out_tready;
  end

  // Stack RAM port selection
  always_comb begin
    ram_we    = cmd.wr_shift || cmd.push;
    ram_waddr = cmd.push ? count_r[AW-1:0] : idx_r[AW-1:0];
    ram_wdata = cmd.push ? note_r : ram_rdata;
    ram_re    = cmd.rd_find || cmd.rd_shift || cmd.rd_top;
    if (cmd.rd_shift) begin
      ram_raddr = idx_plus1[AW-1:0];
    end else if (cmd.rd_top) begin
      ram_raddr = count_m1[AW-1:0];
    end else begin
      ram_raddr = idx_r[AW-1:0];
    end
  end

  mngt_ram #(
    .WIDTH (NOTE_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next values of levels, counters and latched command
  always_comb begin
    pulse_ticks_nxt = cfg_we ? cfg_wdata : pulse_ticks_r;
    elapsed_nxt     = elapsed_r;
    count_nxt       = count_r;
    idx_nxt         = idx_r;
    gate_nxt        = gate_r;
    trig_nxt        = trig_r;
    cur_note_nxt    = cur_note_r;
    cur_vel_nxt     = cur_vel_r;
    note_nxt        = note_r;
    is_on_nxt       = is_on_r;
    err_nxt         = err_r;

    if (cmd.accept) begin
      note_nxt  = in_d1;
      is_on_nxt = in_is_on;
      err_nxt   = (in_tuser == OP_MIDI) && in_is_note && !in_len_ok;
      idx_nxt   = '0;
      if (in_tuser == OP_TICK) begin
        // Count pulse length and end the trigger once it is long enough
        elapsed_nxt = elapsed_inc;
        if (trig_r && (elapsed_inc >= pulse_ticks_r)) begin
          trig_nxt = 1'b0;
        end
      end else if (st.note_cmd && in_is_on) begin
        cur_note_nxt = in_d1;
        cur_vel_nxt  = in_d2;
        gate_nxt     = 1'b1;
        trig_nxt     = 1'b1;
        elapsed_nxt  = '0;
      end
    end

    if (cmd.idx_clr) begin
      idx_nxt = '0;
    end
    if (cmd.idx_inc) begin
      idx_nxt = idx_plus1[CW-1:0];
    end
    if (cmd.count_dec) begin
      count_nxt = count_m1;
    end
    if (cmd.push) begin
      count_nxt = count_r + CW'(1);
    end
    if (cmd.gate_clr) begin
      gate_nxt = 1'b0;
    end
    // Replay the top note and retrigger
    if (cmd.top_load) begin
      cur_note_nxt = ram_rdata;
      trig_nxt     = 1'b1;
      elapsed_nxt  = '0;
    end
  end

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {7'd0, err_r, cur_vel_r, cur_note_r, trig_r, gate_r};
    end
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_ticks_r <= PULSE_TICKS_RESET;
      elapsed_r     <= '0;
      count_r       <= '0;
      gate_r        <= 1'b0;
      trig_r        <= 1'b0;
      cur_note_r    <= NOTE_RESET;
      cur_vel_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      pulse_ticks_r <= pulse_ticks_nxt;
      elapsed_r     <= elapsed_nxt;
      count_r       <= count_nxt;
      gate_r        <= gate_nxt;
      trig_r        <= trig_nxt;
      cur_note_r    <= cur_note_nxt;
      cur_vel_r     <= cur_vel_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    note_r     <= note_nxt;
    is_on_r    <= is_on_nxt;
    err_r      <= err_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== sv/mngt_checker.sv =====
// ---------------------------------------------------------------------------
// mngt_checker: port-level checks for the MIDI note gate/trigger unit
// Watches the stream ports over time; bound to the top level below.
// ---------------------------------------------------------------------------
module mngt_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [mngt_pkg::OUT_DW-1:0] out_tdata
);

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // One item at a time: no accept in the cycle after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after an accepted item");

  // Padding bits of a result stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[23:17] == 7'd0))
    else $error("result padding not zero");

endmodule

bind midi_note_gate_trigger_unit mngt_checker u_mngt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: testbench for midi_note_gate_trigger_unit
// Drives MIDI note messages, malformed and foreign messages and timer ticks
// into the item stream. It predicts gate, trigger, note, velocity and format
// error for each item from its own model of the held-note stack, and compares
// every result item field by field. Both stream sides idle at random, and the
// trigger pulse length is changed between phases while the unit is idle.
// ---------------------------------------------------------------------------
module tb;
  import mngt_pkg::*;

  localparam int DEPTH         = STACK_DEPTH_DEF;
  localparam int MAX_GAP       = 16;
  localparam int SETTLE_CYCLES = 4 * DEPTH + 16;
  localparam int CYCLE_LIMIT   = 800000;

  // Status nibbles that the unit must ignore
  localparam logic [3:0] OPC_POLY_PRESSURE = 4'hA;
  localparam logic [3:0] OPC_CTRL_CHANGE   = 4'hB;
  localparam logic [3:0] OPC_SYSTEM        = 4'hF;

  typedef struct {
    logic              op;
    logic [7:0]        status;
    logic [NOTE_W-1:0] note;
    logic [6:0]        vel;
    logic [1:0]        len;
  } midi_item_t;

  typedef struct {
    logic              gate;
    logic              trig;
    logic [NOTE_W-1:0] note;
    logic [6:0]        vel;
    logic              ferr;
  } level_set_t;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [IN_DW-1:0]    in_tdata;
  logic                in_tuser;
  logic                out_tvalid;
  logic                out_tready;
  logic [OUT_DW-1:0]   out_tdata;
  logic                cfg_we;
  logic [TICKS_W-1:0]  cfg_wdata;

  // Predicted unit state
  logic [NOTE_W-1:0]   held_stack [DEPTH];
  int unsigned         held_fill;
  logic                gate_q;
  logic                trig_q;
  int unsigned         ticks_since_fire;
  logic [TICKS_W-1:0]  pulse_len;
  logic [NOTE_W-1:0]   note_q;
  logic [6:0]          vel_q;

  level_set_t          expected_levels [$];
  level_set_t          want_levels;
  int unsigned         error_count;
  int unsigned         cycle_count;
  int unsigned         recv_wait;
  bit                  send_steady;
  bit                  recv_steady;

  midi_note_gate_trigger_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---- held-note stack model ----

  // Remove one entry and close the gap above it
  function automatic void drop_held(input int unsigned pos);
    for (int unsigned i = pos; i + 1 < held_fill; i++)
      held_stack[i] = held_stack[i + 1];
    if (held_fill > 0)
      held_fill--;
  endfunction

  function automatic bit find_held(input logic [NOTE_W-1:0] n, output int unsigned pos);
    pos = 0;
    for (int unsigned i = 0; i < held_fill; i++) begin
      if (held_stack[i] == n) begin
        pos = i;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void fire_pulse();
    ticks_since_fire = 0;
    trig_q = 1'b1;
  endfunction

  // Advance the model by one item and return the output levels it leaves
  function automatic level_set_t predict_levels(input midi_item_t item);
    level_set_t  r;
    int unsigned pos;
    r.ferr = 1'b0;
    if (item.op == OP_TICK) begin
      if (ticks_since_fire < 32'hFFFF)
        ticks_since_fire++;
      // a length of zero acts as one, which this compare already gives
      if (trig_q && ticks_since_fire >= pulse_len)
        trig_q = 1'b0;
    end else if (item.status[7:4] == OPC_NOTE_ON || item.status[7:4] == OPC_NOTE_OFF) begin
      if (item.len != MSG_LEN_FULL) begin
        r.ferr = 1'b1;
      end else if (item.status[7:4] == OPC_NOTE_ON) begin
        note_q = item.note;
        vel_q  = item.vel;
        gate_q = 1'b1;
        fire_pulse();
        // move a held note to the top, drop the oldest when full
        if (find_held(item.note, pos))
          drop_held(pos);
        if (held_fill >= DEPTH)
          drop_held(0);
        held_stack[held_fill] = item.note;
        held_fill++;
      end else begin
        if (find_held(item.note, pos))
          drop_held(pos);
        if (held_fill == 0) begin
          gate_q = 1'b0;
        end else begin
          // replay the top note, keep the velocity
          note_q = held_stack[held_fill - 1];
          fire_pulse();
        end
      end
    end
    r.gate = gate_q;
    r.trig = trig_q;
    r.note = note_q;
    r.vel  = vel_q;
    return r;
  endfunction

  // ---- stimulus ----

  function automatic midi_item_t make_item(input logic op, input logic [7:0] status,
                                           input logic [6:0] note, input logic [6:0] vel,
                                           input logic [1:0] len);
    midi_item_t item;
    item.op     = op;
    item.status = status;
    item.note   = note;
    item.vel    = vel;
    item.len    = len;
    return item;
  endfunction

  // Send one item; predict its result once the unit takes it
  task automatic send_item(input midi_item_t item);
    int unsigned gap;
    gap = send_steady ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= item.op;
    in_tdata  <= {item.len, item.vel, item.note, item.status};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_levels.push_back(predict_levels(item));
  endtask

  task automatic play_note_on(input logic [3:0] chan, input logic [6:0] note,
                              input logic [6:0] vel);
    send_item(make_item(OP_MIDI, {OPC_NOTE_ON, chan}, note, vel, MSG_LEN_FULL));
  endtask

  task automatic play_note_off(input logic [3:0] chan, input logic [6:0] note);
    send_item(make_item(OP_MIDI, {OPC_NOTE_OFF, chan}, note, 7'($urandom), MSG_LEN_FULL));
  endtask

  // Tick with random payload, which the unit must ignore
  task automatic play_tick();
    send_item(make_item(OP_TICK, 8'($urandom), 7'($urandom), 7'($urandom), 2'($urandom)));
  endtask

  // Hold the input until every pending result has come back
  task automatic drain_results();
    if (in_tvalid) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    while (expected_levels.size() != 0) @(posedge clk);
  endtask

  task automatic set_pulse_length(input logic [TICKS_W-1:0] ticks);
    drain_results();
    repeat (4) @(posedge clk);
    cfg_wdata <= ticks;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    pulse_len  = ticks;
  endtask

  // Levels straight out of reset, note-off on an empty stack
  task automatic test_reset_levels();
    play_tick();
    play_note_off(4'h0, 7'd60);
  endtask

  // Note-on/off handling, bad lengths and foreign status bytes
  task automatic test_note_events();
    play_note_on(4'h0, 7'd0, 7'd127);
    play_note_on(4'hF, 7'd127, 7'd0);
    play_note_on(4'h5, 7'd0, 7'd64);
    play_note_off(4'h0, 7'd0);
    play_note_off(4'hA, 7'd55);
    send_item(make_item(OP_MIDI, {OPC_NOTE_ON, 4'h3}, 7'd10, 7'd10, 2'd0));
    send_item(make_item(OP_MIDI, {OPC_NOTE_ON, 4'h3}, 7'd11, 7'd11, 2'd1));
    send_item(make_item(OP_MIDI, {OPC_NOTE_ON, 4'h3}, 7'd12, 7'd12, 2'd2));
    send_item(make_item(OP_MIDI, {OPC_NOTE_OFF, 4'h7}, 7'd127, 7'd0, 2'd2));
    send_item(make_item(OP_MIDI, {OPC_SYSTEM, 4'h0}, 7'd1, 7'd2, MSG_LEN_FULL));
    send_item(make_item(OP_MIDI, {OPC_POLY_PRESSURE, 4'h3}, 7'd127, 7'd127, MSG_LEN_FULL));
    send_item(make_item(OP_MIDI, {OPC_CTRL_CHANGE, 4'h0}, 7'd127, 7'd127, 2'd1));
    send_item(make_item(OP_MIDI, 8'h00, 7'd0, 7'd0, 2'd0));
    send_item(make_item(OP_MIDI, {OPC_SYSTEM, 4'hF}, 7'd127, 7'd127, MSG_LEN_FULL));
    send_item(make_item(OP_TICK, 8'hFF, 7'd127, 7'd127, 2'd3));
    play_note_off(4'h0, 7'd127);
    play_note_off(4'h0, 7'd127);
  endtask

  // Trigger length, retrigger on note-on and on replay
  task automatic test_pulse_timing();
    set_pulse_length(16'd2);
    play_note_on(4'h1, 7'd40, 7'd90);
    play_tick();
    play_tick();
    play_tick();
    play_note_on(4'h1, 7'd41, 7'd30);
    play_tick();
    play_note_off(4'h1, 7'd41);
    play_tick();
    play_tick();
    play_note_off(4'h1, 7'd40);
  endtask

  // Overfill the stack, then release old, dropped and held notes
  task automatic test_stack_overflow();
    for (int k = 0; k < DEPTH + 3; k++)
      play_note_on(4'($urandom), 7'((20 + 5 * k) % 128), 7'($urandom));
    play_note_on(4'h2, 7'd45, 7'd77);
    for (int k = 0; k < 4; k++)
      play_note_off(4'h2, 7'((20 + 5 * k) % 128));
    while (held_fill > 0)
      play_note_off(4'($urandom), held_stack[$urandom_range(0, held_fill - 1)]);
  endtask

  // Mostly well-formed playing over a note range, with some noise
  task automatic test_random_play(input int n_items, input int note_lo, input int note_hi);
    int unsigned pick;
    for (int k = 0; k < n_items; k++) begin
      // new idling spell now and then
      if (k % 40 == 0) begin
        send_steady = ($urandom_range(0, 3) == 0);
        recv_steady = ($urandom_range(0, 3) == 0);
      end
      if (k == n_items / 2)
        drain_results();
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        play_note_on(4'($urandom), 7'($urandom_range(note_lo, note_hi)), 7'($urandom));
      end else if (pick < 70) begin
        if (held_fill > 0 && $urandom_range(0, 3) != 0)
          play_note_off(4'($urandom), held_stack[$urandom_range(0, held_fill - 1)]);
        else
          play_note_off(4'($urandom), 7'($urandom_range(note_lo, note_hi)));
      end else if (pick < 88) begin
        play_tick();
      end else begin
        send_item(make_item(OP_MIDI, 8'($urandom), 7'($urandom), 7'($urandom), 2'($urandom)));
      end
    end
  endtask

  // ---- result checking ----

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  // Compare each result item, then draw the next stall
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_levels.size() == 0) begin
          $error("result item with nothing pending: tdata %h", out_tdata);
          error_count++;
        end else begin
          want_levels = expected_levels.pop_front();
          check_field("gate", want_levels.gate, out_tdata[0]);
          check_field("trig", want_levels.trig, out_tdata[1]);
          check_field("note_out", want_levels.note, out_tdata[8:2]);
          check_field("velocity_out", want_levels.vel, out_tdata[15:9]);
          check_field("format_error", want_levels.ferr, out_tdata[16]);
        end
        recv_wait = recv_steady ? 0 : $urandom_range(0, MAX_GAP);
        if (recv_wait > 0)
          out_tready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        if (recv_wait == 0)
          out_tready <= 1'b1;
      end
    end
  end

  initial begin
    clk              = 1'b0;
    rst_n            = 1'b0;
    in_tvalid        = 1'b0;
    in_tdata         = '0;
    in_tuser         = 1'b0;
    out_tready       = 1'b1;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    held_fill        = 0;
    gate_q           = 1'b0;
    trig_q           = 1'b0;
    ticks_since_fire = 0;
    pulse_len        = PULSE_TICKS_RESET;
    note_q           = NOTE_RESET;
    vel_q            = '0;
    error_count      = 0;
    cycle_count      = 0;
    recv_wait        = 0;
    send_steady      = 1'b0;
    recv_steady      = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_levels();
    test_note_events();
    test_pulse_timing();
    test_stack_overflow();

    set_pulse_length(16'd1);
    test_random_play(300, 0, 127);
    set_pulse_length(16'hFFFF);
    test_random_play(200, 40, 63);
    set_pulse_length(16'd0);
    test_random_play(200, 0, 20);
    set_pulse_length(16'($urandom_range(2, 12)));
    test_random_play(300, 0, 127);
    set_pulse_length(16'd3);
    test_random_play(200, 100, 127);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
